FILE: design/ufd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared widths and types for the unsigned fractional divider.
// ----------------------------------------------------------------------------
package ufd_pkg;

	// Port field widths (fixed by the interface)
	localparam int unsigned FIELD_WIDTH = 32;
	localparam int unsigned QUOT_WIDTH  = 64;

	// Operand width actually used by the datapath (8..32)
	localparam int unsigned OPERAND_WIDTH = 32;

	// One restoring step per stage, one quotient bit each
	localparam int unsigned STAGES = 2 * OPERAND_WIDTH;

	// Work carried down the stage chain
	typedef struct packed {
		logic [OPERAND_WIDTH-1:0]   num;  // dividend bits still to shift in, MSB first
		logic [OPERAND_WIDTH-1:0]   den;  // divisor
		logic [OPERAND_WIDTH-1:0]   rem;  // partial remainder
		logic [2*OPERAND_WIDTH-1:0] quo;  // quotient bits so far
	} ufd_work_t;

endpackage : ufd_pkg
`default_nettype wire

FILE: design/ufd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_in_if
// Operand channel: valid/ready handshake carrying dividend and divisor.
// ----------------------------------------------------------------------------
interface ufd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [ufd_pkg::FIELD_WIDTH-1:0]      dividend;
	logic [ufd_pkg::FIELD_WIDTH-1:0]      divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);
endinterface : ufd_in_if
`default_nettype wire

FILE: design/ufd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_out_if
// Result channel: valid/ready handshake carrying the 32.32 quotient.
// ----------------------------------------------------------------------------
interface ufd_out_if;
	logic                           valid;
	logic                           ready;
	logic [ufd_pkg::QUOT_WIDTH-1:0] quotient;

	modport source (output valid, output quotient, input ready);
	modport sink   (input valid, input quotient, output ready);
endinterface : ufd_out_if
`default_nettype wire

FILE: design/ufd_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_stage
// One restoring division step: shift in a dividend bit, trial-subtract the
// divisor, keep or restore, and register the result with its valid bit.
// ----------------------------------------------------------------------------
module ufd_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               up_valid,
	input  wire ufd_pkg::ufd_work_t up,
	output logic                    dn_valid,
	output ufd_pkg::ufd_work_t      dn
);
	import ufd_pkg::*;

	logic [OPERAND_WIDTH:0]   shifted;
	logic [OPERAND_WIDTH+1:0] diff;
	logic                     ge;
	ufd_work_t                nxt;
	logic                     valid_s1;
	ufd_work_t                work_s1;

	// Trial subtract; borrow bit tells whether the divisor fits
	always_comb begin
		shifted = {up.rem, up.num[OPERAND_WIDTH-1]};
		diff    = {1'b0, shifted} - {2'b00, up.den};
		ge      = ~diff[OPERAND_WIDTH+1];
		nxt.num = up.num << 1;
		nxt.den = up.den;
		nxt.rem = ge ? diff[OPERAND_WIDTH-1:0] : shifted[OPERAND_WIDTH-1:0];
		nxt.quo = {up.quo[2*OPERAND_WIDTH-2:0], ge};
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	// Payload, loaded only for a live item
	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			work_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn       = work_s1;

endmodule : ufd_stage
`default_nettype wire

FILE: design/ufd_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufd_out_buf
// Output register plus one skid entry. Gives a registered stall signal back
// to the stage chain so the result side never reaches the operand side.
// ----------------------------------------------------------------------------
module ufd_out_buf (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire logic [ufd_pkg::QUOT_WIDTH-1:0] push_data,
	output logic                                advance,
	ufd_out_if.source                           result
);
	import ufd_pkg::*;

	logic                  out_valid_q;
	logic [QUOT_WIDTH-1:0] out_data_q;
	logic                  skid_valid_q;
	logic [QUOT_WIDTH-1:0] skid_data_q;
	logic                  taken;

	assign taken   = out_valid_q & result.ready;
	assign advance = ~skid_valid_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (taken) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Data; skid only fills while the output holds an untaken result
	always_ff @(posedge clk) begin
		if (taken && skid_valid_q) begin
			out_data_q <= skid_data_q;
		end else if (push && (taken || !out_valid_q)) begin
			out_data_q <= push_data;
		end
		if (push && out_valid_q && !taken) begin
			skid_data_q <= push_data;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.quotient = out_data_q;

	// Skid only holds an item while the output register is full
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds an item while the output register is empty");

	// Skid fills only when a result was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !result.ready))
		else $error("skid entry filled without a stalled result");

	// A pushed result is never dropped
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("result pushed from the stage chain was lost");

endmodule : ufd_out_buf
`default_nettype wire

FILE: design/unsigned_fractional_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_fractional_divider
// Pipelined restoring divider: floor(dividend * 2^32 / divisor) as 32.32.
// ----------------------------------------------------------------------------
// Accepts one dividend/divisor pair per clock while the result side keeps
// up, returning the 64-bit 32.32 fixed-point quotient (upper word integer
// part, lower word truncated fraction). The datapath is a chain of 64
// restoring stages, each producing one quotient bit with a single 34-bit
// subtract, followed by an output register. Throughput is one division per
// cycle while the result side keeps up. A divide by zero returns all ones.
// When the result side stalls, one extra result is caught in a skid entry and
// then the whole stage chain freezes, with operand ready dropping; nothing
// is lost or repeated. No state is kept between items.
module unsigned_fractional_divider (
	input  wire logic clk,
	input  wire logic arst_n,
	ufd_in_if.sink    operands,
	ufd_out_if.source result
);
	import ufd_pkg::*;

	logic      advance;
	logic      valid_s [STAGES+1];
	ufd_work_t work_s  [STAGES+1];

	// Stage chain entry: remainder and quotient start at zero
	assign operands.ready = advance;
	assign valid_s[0]     = operands.valid;
	always_comb begin
		work_s[0].num = operands.dividend[OPERAND_WIDTH-1:0];
		work_s[0].den = operands.divisor[OPERAND_WIDTH-1:0];
		work_s[0].rem = '0;
		work_s[0].quo = '0;
	end

	// One quotient bit per stage
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		ufd_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.up_valid (valid_s[i]),
			.up       (work_s[i]),
			.dn_valid (valid_s[i+1]),
			.dn       (work_s[i+1])
		);
	end

	// Output register and skid
	ufd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s[STAGES] & advance),
		.push_data (QUOT_WIDTH'(work_s[STAGES].quo)),
		.advance   (advance),
		.result    (result)
	);

	// Zero divisor must yield all quotient bits set
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[STAGES] && (work_s[STAGES].den == '0)) |-> (&work_s[STAGES].quo))
		else $error("zero divisor did not give an all-ones quotient");

	// Final remainder stays below a nonzero divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s[STAGES] && (work_s[STAGES].den != '0))
			|-> (work_s[STAGES].rem < work_s[STAGES].den))
		else $error("final remainder not below the divisor");

	// Frozen chain holds its last stage
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(valid_s[STAGES]))
		else $error("stage chain moved while stalled");

endmodule : unsigned_fractional_divider
`default_nettype wire

FILE: sim/tb_unsigned_fractional_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_unsigned_fractional_divider
// Self-checking bench for the pipelined 32.32 restoring divider.
// ----------------------------------------------------------------------------
// Operand pairs go in over the operand channel. A first short list covers
// the corner cases: zero and full-scale operands, divide by zero, a dividend
// below the divisor, and powers of two. A long random run follows, mixing
// operand shapes. Both channel ends idle at random. Twice the result side
// holds off for a long stretch while operands keep coming, which fills the
// stage chain and backs up the input. Every operand transfer queues a
// locally computed quotient, and every result transfer is checked in order
// against it.
module tb_unsigned_fractional_divider;

	import ufd_pkg::*;

	localparam int RANDOM_PAIRS   = 1000;
	localparam int LONG_HOLD      = 300;
	localparam int BURST_PAIRS    = 150;
	localparam int DRAIN_CYCLES   = 120;

	// Expected quotients in transfer order, with the divide done locally
	class quotient_scoreboard;
		logic [QUOT_WIDTH-1:0] expected_quotients[$];
		int                    errors;

		function new();
			errors = 0;
		endfunction

		// floor(dividend * 2^W / divisor), one quotient bit per step, MSB first
		function logic [QUOT_WIDTH-1:0] frac_quotient(logic [FIELD_WIDTH-1:0] dividend,
				logic [FIELD_WIDTH-1:0] divisor);
			int          w;
			int          pos;
			logic [63:0] mask;
			logic [63:0] num;
			logic [63:0] den;
			logic [63:0] rem;
			logic [63:0] quo;
			w    = OPERAND_WIDTH;
			mask = (64'd1 << w) - 64'd1;
			num  = {32'd0, dividend} & mask;
			den  = {32'd0, divisor} & mask;
			rem  = '0;
			quo  = '0;
			for (pos = 2 * w - 1; pos >= 0; pos--) begin
				// dividend bits enter only over the upper W positions
				rem = rem << 1;
				if (pos >= w)
					rem[0] = num[pos - w];
				if (rem >= den) begin
					rem      = rem - den;
					quo[pos] = 1'b1;
				end
			end
			return quo;
		endfunction

		function void note_operands(logic [FIELD_WIDTH-1:0] dividend,
				logic [FIELD_WIDTH-1:0] divisor);
			expected_quotients.push_back(frac_quotient(dividend, divisor));
		endfunction

		function void check_quotient(logic [QUOT_WIDTH-1:0] quotient);
			logic [QUOT_WIDTH-1:0] want;
			if (expected_quotients.size() == 0) begin
				$error("quotient: result transfer with none expected, actual %h", quotient);
				errors++;
			end else begin
				want = expected_quotients.pop_front();
				if (quotient !== want) begin
					$error("quotient: expected %h actual %h", want, quotient);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_quotients.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ufd_in_if  operands_if ();
	ufd_out_if result_if ();

	unsigned_fractional_divider uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (operands_if),
		.result   (result_if)
	);

	quotient_scoreboard quot_sb;

	// Shared idling controls
	bit sender_quiet;
	bit receiver_quiet;
	bit hold_request;
	int burst_left;

	// 100 MHz clock
	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("tb_unsigned_fractional_divider: errors");
		$finish;
	end

	// Transfer monitor: values seen here are the ones from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (operands_if.valid && operands_if.ready)
				quot_sb.note_operands(operands_if.dividend, operands_if.divisor);
			if (result_if.valid && result_if.ready)
				quot_sb.check_quotient(result_if.quotient);
		end
	end

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	// Offer one operand pair after a random gap (none while quiet or in a burst), return once it has transferred
	task automatic send_pair(input logic [FIELD_WIDTH-1:0] dividend,
			input logic [FIELD_WIDTH-1:0] divisor);
		int gap;
		gap = (burst_left > 0) ? 0 : draw_wait(sender_quiet);
		if (burst_left > 0)
			burst_left--;
		if (gap > 0) begin
			operands_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operands_if.valid    <= 1'b1;
		operands_if.dividend <= dividend;
		operands_if.divisor  <= divisor;
		do @(posedge clk); while (!operands_if.ready);
	endtask

	// Random operand pair of a randomly chosen shape
	task automatic random_pair(output logic [FIELD_WIDTH-1:0] dividend,
			output logic [FIELD_WIDTH-1:0] divisor);
		dividend = $urandom;
		divisor  = $urandom;
		case ($urandom_range(0, 9))
			0: divisor = '0;
			1: divisor = $urandom_range(1, 255);
			2: begin
				if (divisor == '0)
					divisor = 32'd1;
				dividend = dividend % divisor;
			end
			3: begin
				dividend = $urandom_range(0, 1023);
				divisor  = $urandom_range(0, 1023);
			end
			4: divisor = 32'd1 << $urandom_range(0, 31);
			5: begin
				if ($urandom_range(0, 1))
					dividend = '1;
				else
					divisor = '1;
			end
			6: divisor = dividend ^ (32'd1 << $urandom_range(0, 31));
			default: ;
		endcase
	endtask

	// Result side: random stalls, plus the long hold-off on request
	initial begin
		int stall;
		result_if.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			stall = draw_wait(receiver_quiet);
			if (hold_request) begin
				hold_request = 1'b0;
				stall        = LONG_HOLD;
			end
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
		end
	end

	// Stimulus and end of run
	initial begin
		logic [FIELD_WIDTH-1:0] dividend;
		logic [FIELD_WIDTH-1:0] divisor;
		logic [FIELD_WIDTH-1:0] corner_dividends[$];
		logic [FIELD_WIDTH-1:0] corner_divisors[$];
		int                     idx;
		int                     mode;

		quot_sb              = new();
		sender_quiet         = 1'b0;
		receiver_quiet       = 1'b0;
		hold_request         = 1'b0;
		burst_left           = 0;
		arst_n               = 1'b0;
		operands_if.valid    = 1'b0;
		operands_if.dividend = '0;
		operands_if.divisor  = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases: zeros, full scale, divide by zero, small over large
		corner_dividends = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h0000_0001, 32'h0000_0003, 32'h8000_0000, 32'hAAAA_AAAA,
			32'h5555_5555, 32'h0000_0007, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFE, 32'h0000_0064, 32'h0001_0000, 32'hDEAD_BEEF};
		corner_divisors  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
			32'h0000_0001, 32'h0000_0007, 32'h0000_0002, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h0000_0003, 32'h8000_0000, 32'h8000_0001,
			32'hFFFF_FFFF, 32'h0000_0064, 32'h0000_0100, 32'h0000_0011};
		foreach (corner_dividends[i])
			send_pair(corner_dividends[i], corner_divisors[i]);

		// Random run; idling style changes every hundred pairs
		for (idx = 0; idx < RANDOM_PAIRS; idx++) begin
			if (idx % 100 == 0) begin
				mode           = $urandom_range(0, 3);
				sender_quiet   = (mode == 1) || (mode == 3);
				receiver_quiet = (mode == 2) || (mode == 3);
			end
			// long result hold-off with a back-to-back operand burst behind it
			if (idx == 300 || idx == 700) begin
				hold_request = 1'b1;
				burst_left   = BURST_PAIRS;
			end
			random_pair(dividend, divisor);
			send_pair(dividend, divisor);
		end
		operands_if.valid <= 1'b0;

		// Drain, then watch for stray results
		while (quot_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (quot_sb.errors == 0 && quot_sb.pending() == 0)
			$display("tb_unsigned_fractional_divider: clean");
		else
			$display("tb_unsigned_fractional_divider: errors");
		$finish;
	end

endmodule : tb_unsigned_fractional_divider
`default_nettype wire

FILE: unsigned_fractional_divider.f
design/ufd_pkg.sv
design/ufd_in_if.sv
design/ufd_out_if.sv
design/ufd_stage.sv
design/ufd_out_buf.sv
design/unsigned_fractional_divider.sv
sim/tb_unsigned_fractional_divider.sv
